// ===== hdl/rti_pkg.sv =====
`timescale 1ns / 1ps
package rti_pkg;

   // field and datapath widths
   localparam int COORD_W   = 32;
   localparam int EPS_W     = 31;
   localparam int EDGE_W    = 33;
   localparam int PPROD_W   = 65;
   localparam int QPROD_W   = 66;
   localparam int CROSS_P_W = 66;
   localparam int CROSS_Q_W = 67;
   localparam int SPLIT_W   = 32;
   localparam int LO_W      = 66;
   localparam int HI_W      = 68;
   localparam int SUMLO_W   = 68;
   localparam int SUMHI_W   = 70;
   localparam int WIDE_W    = 100;
   localparam int UVSUM_W   = 101;
   localparam int MAG_W     = 98;
   localparam int TT_W      = 99;
   localparam int QUO_W     = 32;
   localparam int NUM_DOTS  = 4;
   localparam int GEO_STAGES = 9;

   // dot product slots
   localparam int DOT_DET = 0;
   localparam int DOT_U   = 1;
   localparam int DOT_V   = 2;
   localparam int DOT_T   = 3;

   // register indexes
   localparam int REG_IDX_W = 3;
   localparam logic [REG_IDX_W-1:0] REG_ORIGIN_X = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_ORIGIN_Y = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_ORIGIN_Z = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_DIR_X    = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_DIR_Y    = 3'd4;
   localparam logic [REG_IDX_W-1:0] REG_DIR_Z    = 3'd5;
   localparam logic [REG_IDX_W-1:0] REG_DET_EPS  = 3'd6;

   localparam logic [COORD_W-1:0] DIST_MISS = 32'h8000_0000;
   localparam logic [COORD_W-1:0] DIST_MAX  = 32'h7FFF_FFFF;

   typedef struct packed {
      logic signed [COORD_W-1:0] origin_x;
      logic signed [COORD_W-1:0] origin_y;
      logic signed [COORD_W-1:0] origin_z;
      logic signed [COORD_W-1:0] dir_x;
      logic signed [COORD_W-1:0] dir_y;
      logic signed [COORD_W-1:0] dir_z;
      logic [EPS_W-1:0]          det_epsilon;
   } rti_cfg_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] a_x;
      logic signed [COORD_W-1:0] a_y;
      logic signed [COORD_W-1:0] a_z;
      logic signed [COORD_W-1:0] b_x;
      logic signed [COORD_W-1:0] b_y;
      logic signed [COORD_W-1:0] b_z;
      logic signed [COORD_W-1:0] c_x;
      logic signed [COORD_W-1:0] c_y;
      logic signed [COORD_W-1:0] c_z;
   } rti_vert_type;

   typedef struct packed {
      logic             valid;
      logic             miss;
      logic [TT_W-1:0]  tt;
      logic [MAG_W-1:0] mag;
   } rti_div_in_type;

   typedef struct packed {
      logic               valid;
      logic               hit;
      logic [COORD_W-1:0] distance;
   } rti_res_type;

endpackage

// ===== hdl/rti_geom.sv =====
`timescale 1ns / 1ps
module rti_geom import rti_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           adv,
   input  logic           in_valid,
   input  rti_vert_type   vert,
   input  rti_cfg_type    cfg,
   output rti_div_in_type dout
);

   logic [GEO_STAGES-1:0] vld_ff;

   logic signed [COORD_W-1:0] dir_v [3];
   logic signed [COORD_W-1:0] org_v [3];
   logic signed [COORD_W-1:0] va_v [3];
   logic signed [COORD_W-1:0] vb_v [3];
   logic signed [COORD_W-1:0] vc_v [3];

   assign dir_v[0] = cfg.dir_x;
   assign dir_v[1] = cfg.dir_y;
   assign dir_v[2] = cfg.dir_z;
   assign org_v[0] = cfg.origin_x;
   assign org_v[1] = cfg.origin_y;
   assign org_v[2] = cfg.origin_z;
   assign va_v[0]  = vert.a_x;
   assign va_v[1]  = vert.a_y;
   assign va_v[2]  = vert.a_z;
   assign vb_v[0]  = vert.b_x;
   assign vb_v[1]  = vert.b_y;
   assign vb_v[2]  = vert.b_z;
   assign vc_v[0]  = vert.c_x;
   assign vc_v[1]  = vert.c_y;
   assign vc_v[2]  = vert.c_z;

   // advance valid bits with the data
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[GEO_STAGES-2:0], in_valid};
      end
   end

   // stage 1: edges and origin offset
   logic signed [EDGE_W-1:0] e1_in [3];
   logic signed [EDGE_W-1:0] e2_in [3];
   logic signed [EDGE_W-1:0] s_in  [3];
   logic signed [EDGE_W-1:0] e1_1_ff [3];
   logic signed [EDGE_W-1:0] e2_1_ff [3];
   logic signed [EDGE_W-1:0] s_1_ff  [3];

   always_comb begin
      for (int j = 0; j < 3; j++) begin
         e1_in[j] = EDGE_W'(vb_v[j]) - EDGE_W'(va_v[j]);
         e2_in[j] = EDGE_W'(vc_v[j]) - EDGE_W'(va_v[j]);
         s_in[j]  = EDGE_W'(org_v[j]) - EDGE_W'(va_v[j]);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         e1_1_ff <= e1_in;
         e2_1_ff <= e2_in;
         s_1_ff  <= s_in;
      end
   end

   // stage 2: cross product terms of dir x e2 and s x e1
   logic signed [PPROD_W-1:0] pp_in [6];
   logic signed [QPROD_W-1:0] qp_in [6];
   logic signed [PPROD_W-1:0] pp_ff [6];
   logic signed [QPROD_W-1:0] qp_ff [6];
   logic signed [EDGE_W-1:0]  e1_2_ff [3];
   logic signed [EDGE_W-1:0]  e2_2_ff [3];
   logic signed [EDGE_W-1:0]  s_2_ff  [3];

   always_comb begin
      pp_in[0] = PPROD_W'(dir_v[1]) * PPROD_W'(e2_1_ff[2]);
      pp_in[1] = PPROD_W'(dir_v[2]) * PPROD_W'(e2_1_ff[1]);
      pp_in[2] = PPROD_W'(dir_v[2]) * PPROD_W'(e2_1_ff[0]);
      pp_in[3] = PPROD_W'(dir_v[0]) * PPROD_W'(e2_1_ff[2]);
      pp_in[4] = PPROD_W'(dir_v[0]) * PPROD_W'(e2_1_ff[1]);
      pp_in[5] = PPROD_W'(dir_v[1]) * PPROD_W'(e2_1_ff[0]);
      qp_in[0] = QPROD_W'(s_1_ff[1]) * QPROD_W'(e1_1_ff[2]);
      qp_in[1] = QPROD_W'(s_1_ff[2]) * QPROD_W'(e1_1_ff[1]);
      qp_in[2] = QPROD_W'(s_1_ff[2]) * QPROD_W'(e1_1_ff[0]);
      qp_in[3] = QPROD_W'(s_1_ff[0]) * QPROD_W'(e1_1_ff[2]);
      qp_in[4] = QPROD_W'(s_1_ff[0]) * QPROD_W'(e1_1_ff[1]);
      qp_in[5] = QPROD_W'(s_1_ff[1]) * QPROD_W'(e1_1_ff[0]);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         pp_ff   <= pp_in;
         qp_ff   <= qp_in;
         e1_2_ff <= e1_1_ff;
         e2_2_ff <= e2_1_ff;
         s_2_ff  <= s_1_ff;
      end
   end

   // stage 3: cross products P and Q
   logic signed [CROSS_P_W-1:0] p_in [3];
   logic signed [CROSS_Q_W-1:0] q_in [3];
   logic signed [CROSS_P_W-1:0] p_ff [3];
   logic signed [CROSS_Q_W-1:0] q_ff [3];
   logic signed [EDGE_W-1:0]    e1_3_ff [3];
   logic signed [EDGE_W-1:0]    e2_3_ff [3];
   logic signed [EDGE_W-1:0]    s_3_ff  [3];

   always_comb begin
      for (int j = 0; j < 3; j++) begin
         p_in[j] = CROSS_P_W'(pp_ff[2*j]) - CROSS_P_W'(pp_ff[2*j+1]);
         q_in[j] = CROSS_Q_W'(qp_ff[2*j]) - CROSS_Q_W'(qp_ff[2*j+1]);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p_ff    <= p_in;
         q_ff    <= q_in;
         e1_3_ff <= e1_2_ff;
         e2_3_ff <= e2_2_ff;
         s_3_ff  <= s_2_ff;
      end
   end

   // stage 4: partial products of the four dot products, P and Q split in halves
   logic signed [SPLIT_W:0]               pl [3];
   logic signed [CROSS_P_W-SPLIT_W-1:0]   ph [3];
   logic signed [SPLIT_W:0]               ql [3];
   logic signed [CROSS_Q_W-SPLIT_W-1:0]   qh [3];
   logic signed [LO_W-1:0] lo_in [NUM_DOTS][3];
   logic signed [HI_W-1:0] hi_in [NUM_DOTS][3];
   logic signed [LO_W-1:0] lo_ff [NUM_DOTS][3];
   logic signed [HI_W-1:0] hi_ff [NUM_DOTS][3];

   always_comb begin
      for (int j = 0; j < 3; j++) begin
         pl[j] = $signed({1'b0, p_ff[j][SPLIT_W-1:0]});
         ph[j] = $signed(p_ff[j][CROSS_P_W-1:SPLIT_W]);
         ql[j] = $signed({1'b0, q_ff[j][SPLIT_W-1:0]});
         qh[j] = $signed(q_ff[j][CROSS_Q_W-1:SPLIT_W]);
         lo_in[DOT_DET][j] = LO_W'(e1_3_ff[j]) * LO_W'(pl[j]);
         hi_in[DOT_DET][j] = HI_W'(e1_3_ff[j]) * HI_W'(ph[j]);
         lo_in[DOT_U][j]   = LO_W'(s_3_ff[j]) * LO_W'(pl[j]);
         hi_in[DOT_U][j]   = HI_W'(s_3_ff[j]) * HI_W'(ph[j]);
         lo_in[DOT_V][j]   = LO_W'(dir_v[j]) * LO_W'(ql[j]);
         hi_in[DOT_V][j]   = HI_W'(dir_v[j]) * HI_W'(qh[j]);
         lo_in[DOT_T][j]   = LO_W'(e2_3_ff[j]) * LO_W'(ql[j]);
         hi_in[DOT_T][j]   = HI_W'(e2_3_ff[j]) * HI_W'(qh[j]);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         lo_ff <= lo_in;
         hi_ff <= hi_in;
      end
   end

   // stage 5: sum the low and high halves apart
   logic signed [SUMLO_W-1:0] slo_in [NUM_DOTS];
   logic signed [SUMHI_W-1:0] shi_in [NUM_DOTS];
   logic signed [SUMLO_W-1:0] slo_ff [NUM_DOTS];
   logic signed [SUMHI_W-1:0] shi_ff [NUM_DOTS];

   always_comb begin
      for (int k = 0; k < NUM_DOTS; k++) begin
         slo_in[k] = SUMLO_W'(lo_ff[k][0]) + SUMLO_W'(lo_ff[k][1]) + SUMLO_W'(lo_ff[k][2]);
         shi_in[k] = SUMHI_W'(hi_ff[k][0]) + SUMHI_W'(hi_ff[k][1]) + SUMHI_W'(hi_ff[k][2]);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         slo_ff <= slo_in;
         shi_ff <= shi_in;
      end
   end

   // stage 6: join halves into det, U, V, T
   logic signed [WIDE_W-1:0] dot_in [NUM_DOTS];
   logic signed [WIDE_W-1:0] dot_ff [NUM_DOTS];

   always_comb begin
      for (int k = 0; k < NUM_DOTS; k++) begin
         dot_in[k] = (WIDE_W'(shi_ff[k]) <<< SPLIT_W) + WIDE_W'(slo_ff[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dot_ff <= dot_in;
      end
   end

   // stage 7: fold the sign of det into U, V, T
   logic                     flip;
   logic signed [WIDE_W-1:0] neg_det;
   logic [MAG_W-1:0]         mag_in;
   logic signed [WIDE_W-1:0] uu_in, vv_in, tt_in;
   logic                     dz_in;
   logic [MAG_W-1:0]         mag_7_ff;
   logic signed [WIDE_W-1:0] uu_ff, vv_ff, tt_7_ff;
   logic                     dz_ff;

   always_comb begin
      flip    = dot_ff[DOT_DET][WIDE_W-1];
      neg_det = -dot_ff[DOT_DET];
      mag_in  = flip ? neg_det[MAG_W-1:0] : dot_ff[DOT_DET][MAG_W-1:0];
      uu_in   = flip ? -dot_ff[DOT_U] : dot_ff[DOT_U];
      vv_in   = flip ? -dot_ff[DOT_V] : dot_ff[DOT_V];
      tt_in   = flip ? -dot_ff[DOT_T] : dot_ff[DOT_T];
      dz_in   = (dot_ff[DOT_DET] == '0);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         mag_7_ff <= mag_in;
         uu_ff    <= uu_in;
         vv_ff    <= vv_in;
         tt_7_ff  <= tt_in;
         dz_ff    <= dz_in;
      end
   end

   // stage 8: parallel, range and distance sign tests
   logic [WIDE_W-1:0]         lim;
   logic signed [WIDE_W-1:0]  mag_s;
   logic signed [UVSUM_W-1:0] uvs_in;
   logic                      missa_in;
   logic signed [UVSUM_W-1:0] uvs_ff;
   logic                      missa_ff;
   logic [MAG_W-1:0]          mag_8_ff;
   logic [TT_W-1:0]           tt_8_ff;

   always_comb begin
      lim      = WIDE_W'(cfg.det_epsilon) << (2 * FRAC_BITS);
      mag_s    = $signed({{(WIDE_W-MAG_W){1'b0}}, mag_7_ff});
      uvs_in   = UVSUM_W'(uu_ff) + UVSUM_W'(vv_ff);
      missa_in = dz_ff
               | ({{(WIDE_W-MAG_W){1'b0}}, mag_7_ff} < lim)
               | uu_ff[WIDE_W-1]
               | (mag_s < uu_ff)
               | vv_ff[WIDE_W-1]
               | tt_7_ff[WIDE_W-1]
               | (tt_7_ff == '0);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         uvs_ff   <= uvs_in;
         missa_ff <= missa_in;
         mag_8_ff <= mag_7_ff;
         tt_8_ff  <= tt_7_ff[TT_W-1:0];
      end
   end

   // stage 9: u + v against one
   logic             miss_in;
   logic             miss_ff;
   logic [MAG_W-1:0] mag_9_ff;
   logic [TT_W-1:0]  tt_9_ff;

   assign miss_in = missa_ff
                  | ($signed({{(UVSUM_W-MAG_W){1'b0}}, mag_8_ff}) < uvs_ff);

   always_ff @(posedge clock) begin
      if (adv) begin
         miss_ff  <= miss_in;
         mag_9_ff <= mag_8_ff;
         tt_9_ff  <= tt_8_ff;
      end
   end

   always_comb begin
      dout.valid = vld_ff[GEO_STAGES-1];
      dout.miss  = miss_ff;
      dout.tt    = tt_9_ff;
      dout.mag   = mag_9_ff;
   end

endmodule

// ===== hdl/rti_div.sv =====
`timescale 1ns / 1ps
module rti_div import rti_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           adv,
   input  rti_div_in_type din,
   output rti_res_type    res
);

   localparam int NUM_W = TT_W + FRAC_BITS;
   localparam int LAST  = QUO_W - 1;

   logic [NUM_W-1:0] rem_ff [LAST];
   logic [MAG_W-1:0] mag_ff [LAST];
   logic [QUO_W-1:0] quo_ff [QUO_W];
   logic             miss_ff [QUO_W];
   logic [QUO_W-1:0] vld_ff;

   // advance valid bits with the data
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[QUO_W-2:0], din.valid};
      end
   end

   // one quotient bit per stage, most significant first
   for (genvar k = 0; k < QUO_W; k++) begin : g_step
      localparam int BIT = QUO_W - 1 - k;
      logic [NUM_W-1:0] rem_src;
      logic [MAG_W-1:0] mag_src;
      logic [QUO_W-1:0] quo_src;
      logic             miss_src;
      logic [NUM_W-1:0] dvs;
      logic             ge;
      logic [QUO_W-1:0] quo_in;

      if (k == 0) begin : g_head
         assign rem_src  = {din.tt, {FRAC_BITS{1'b0}}};
         assign mag_src  = din.mag;
         assign quo_src  = '0;
         assign miss_src = din.miss;
      end else begin : g_body
         assign rem_src  = rem_ff[k-1];
         assign mag_src  = mag_ff[k-1];
         assign quo_src  = quo_ff[k-1];
         assign miss_src = miss_ff[k-1];
      end

      always_comb begin
         dvs         = NUM_W'(mag_src);
         ge          = (rem_src >> BIT) >= dvs;
         quo_in      = quo_src;
         quo_in[BIT] = ge;
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            quo_ff[k]  <= quo_in;
            miss_ff[k] <= miss_src;
         end
      end

      if (k < LAST) begin : g_carry
         logic [NUM_W-1:0] rem_in;
         assign rem_in = ge ? (rem_src - (dvs << BIT)) : rem_src;
         always_ff @(posedge clock) begin
            if (adv) begin
               rem_ff[k] <= rem_in;
               mag_ff[k] <= mag_src;
            end
         end
      end
   end

   // saturate and mark misses
   logic hit;

   assign hit = !miss_ff[LAST] && (quo_ff[LAST] != '0);

   always_comb begin
      res.valid = vld_ff[LAST];
      res.hit   = hit;
      if (!hit) begin
         res.distance = DIST_MISS;
      end else if (quo_ff[LAST][QUO_W-1]) begin
         res.distance = DIST_MAX;
      end else begin
         res.distance = quo_ff[LAST];
      end
   end

endmodule

// ===== hdl/rti_obuf.sv =====
`timescale 1ns / 1ps
module rti_obuf import rti_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               adv,
   input  rti_res_type        res,
   input  logic               rsp_stall,
   output logic               rsp_valid,
   output logic               rsp_hit,
   output logic [COORD_W-1:0] rsp_distance,
   output logic               full
);

   logic               out_valid_ff, skid_valid_ff;
   logic               out_hit_ff, skid_hit_ff;
   logic [COORD_W-1:0] out_dist_ff, skid_dist_ff;
   logic               push, take;

   assign push = adv && res.valid;
   assign take = out_valid_ff && !rsp_stall;

   // hold results in the output register, overflow into the skid stage
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (push) begin
         if (!out_valid_ff || take) begin
            out_valid_ff <= 1'b1;
         end else begin
            skid_valid_ff <= 1'b1;
         end
      end else if (take) begin
         out_valid_ff  <= skid_valid_ff;
         skid_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         if (!out_valid_ff || take) begin
            out_hit_ff  <= res.hit;
            out_dist_ff <= res.distance;
         end else begin
            skid_hit_ff  <= res.hit;
            skid_dist_ff <= res.distance;
         end
      end else if (take) begin
         out_hit_ff  <= skid_hit_ff;
         out_dist_ff <= skid_dist_ff;
      end
   end

   assign rsp_valid    = out_valid_ff;
   assign rsp_hit      = out_hit_ff;
   assign rsp_distance = out_dist_ff;
   assign full         = skid_valid_ff;

endmodule

// ===== hdl/ray_triangle_intersect_unit.sv =====
`timescale 1ns / 1ps
// Ray / triangle intersection, Moller-Trumbore, signed fixed point with
// FRAC_BITS fraction bits. The ray origin, direction and determinant epsilon
// sit in seven registers written through the csr_ port (index 0..6 in the
// order origin x y z, direction x y z, epsilon); write them only while the
// unit is idle. Each req_ transaction carries one triangle (vertices A, B, C)
// and gives exactly one rsp_ transaction: hit, and the distance t, or the
// most negative value on a miss.
// A result passes through nine geometry stages (edges, cross products, split
// wide dot products, sign fold and range tests), a 32-stage divider that
// retires one quotient bit per stage, and the output register. Throughput:
// one triangle per cycle while req_stall is low.
// Reset (synchronous) empties the pipeline and loads origin 0, direction 0,
// epsilon 1. When the receiver stalls, the result holds in the output
// register and one more lands in a skid stage; req_stall then rises and
// the whole pipeline holds until the skid stage drains.
module ray_triangle_intersect_unit import rti_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic signed [COORD_W-1:0]   req_a_x,
   input  logic signed [COORD_W-1:0]   req_a_y,
   input  logic signed [COORD_W-1:0]   req_a_z,
   input  logic signed [COORD_W-1:0]   req_b_x,
   input  logic signed [COORD_W-1:0]   req_b_y,
   input  logic signed [COORD_W-1:0]   req_b_z,
   input  logic signed [COORD_W-1:0]   req_c_x,
   input  logic signed [COORD_W-1:0]   req_c_y,
   input  logic signed [COORD_W-1:0]   req_c_z,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic                        rsp_hit,
   output logic signed [COORD_W-1:0]   rsp_distance,
   input  logic                        csr_we,
   input  logic [REG_IDX_W-1:0]        csr_index,
   input  logic [COORD_W-1:0]          csr_wdata
);

   rti_cfg_type    cfg_ff;
   rti_vert_type   vert;
   rti_div_in_type geo_out;
   rti_res_type    res;
   logic           adv;
   logic           full;
   logic [COORD_W-1:0] dist_out;

   // configuration registers, unknown indexes dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.origin_x    <= '0;
         cfg_ff.origin_y    <= '0;
         cfg_ff.origin_z    <= '0;
         cfg_ff.dir_x       <= '0;
         cfg_ff.dir_y       <= '0;
         cfg_ff.dir_z       <= '0;
         cfg_ff.det_epsilon <= EPS_W'(1);
      end else if (csr_we) begin
         case (csr_index)
            REG_ORIGIN_X: cfg_ff.origin_x    <= csr_wdata;
            REG_ORIGIN_Y: cfg_ff.origin_y    <= csr_wdata;
            REG_ORIGIN_Z: cfg_ff.origin_z    <= csr_wdata;
            REG_DIR_X:    cfg_ff.dir_x       <= csr_wdata;
            REG_DIR_Y:    cfg_ff.dir_y       <= csr_wdata;
            REG_DIR_Z:    cfg_ff.dir_z       <= csr_wdata;
            REG_DET_EPS:  cfg_ff.det_epsilon <= csr_wdata[EPS_W-1:0];
            default: ;
         endcase
      end
   end

   // advance the pipeline while the skid stage is empty
   assign adv       = !full;
   assign req_stall = full;

   always_comb begin
      vert.a_x = req_a_x;
      vert.a_y = req_a_y;
      vert.a_z = req_a_z;
      vert.b_x = req_b_x;
      vert.b_y = req_b_y;
      vert.b_z = req_b_z;
      vert.c_x = req_c_x;
      vert.c_y = req_c_y;
      vert.c_z = req_c_z;
   end

   rti_geom #(
      .FRAC_BITS (FRAC_BITS)
   ) u_geom (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_valid (req_valid),
      .vert     (vert),
      .cfg      (cfg_ff),
      .dout     (geo_out)
   );

   rti_div #(
      .FRAC_BITS (FRAC_BITS)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .adv   (adv),
      .din   (geo_out),
      .res   (res)
   );

   rti_obuf u_obuf (
      .clock        (clock),
      .reset        (reset),
      .adv          (adv),
      .res          (res),
      .rsp_stall    (rsp_stall),
      .rsp_valid    (rsp_valid),
      .rsp_hit      (rsp_hit),
      .rsp_distance (dist_out),
      .full         (full)
   );

   assign rsp_distance = $signed(dist_out);

endmodule
